// ===== rtl/zfs_pkg.sv =====
// zfs_pkg: shared types, codes and constants of the zstd frame scanner
package zfs_pkg;

  typedef enum logic [2:0] {
    EV_HDR_DONE = 3'd0,
    EV_BLOCK    = 3'd1,
    EV_FRM_END  = 3'd2,
    EV_REPORT   = 3'd3,
    EV_ERROR    = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    FK_FILE_MAGIC = 3'd0,
    FK_GENOMIC    = 3'd1,
    FK_PARALLEL   = 3'd2,
    FK_SEEKABLE   = 3'd3,
    FK_DATA       = 3'd4,
    FK_SKIPPABLE  = 3'd5
  } kind_t;

  typedef enum logic {
    ERR_BAD_MAGIC = 1'b0,
    ERR_TRUNCATED = 1'b1
  } err_t;

  localparam logic [2:0] CID_MAGIC    = 3'd0;
  localparam logic [2:0] CID_DATA     = 3'd1;
  localparam logic [2:0] CID_PARALLEL = 3'd2;
  localparam logic [2:0] CID_GENOMIC  = 3'd3;
  localparam logic [2:0] CID_SEEKABLE = 3'd4;
  localparam logic [2:0] CID_BLOCKS   = 3'd5;
  localparam int         NUM_CNT      = 6;

  localparam logic [1:0] BT_RLE = 2'd1;

  localparam logic [31:0] MAGIC_CONTAINER = 32'h184D2A5B;
  localparam logic [31:0] MAGIC_PARALLEL  = 32'h184D2A50;
  localparam logic [31:0] MAGIC_SEEKABLE  = 32'h184D2A5E;
  localparam logic [31:0] MAGIC_DATA      = 32'hFD2FB528;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    event_t      event_res;
    kind_t       frame_kind;
    logic        block_last;
    logic [1:0]  blk_type;
    logic [63:0] value;
    logic        size_present;
    logic [2:0]  counter_id;
    err_t        error_code;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== rtl/zfs_in_if.sv =====
// zfs_in_if: byte stream channel of the zstd frame scanner
interface zfs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// ===== rtl/zfs_out_if.sv =====
// zfs_out_if: result channel of the zstd frame scanner
interface zfs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  frame_kind;
  logic        block_last;
  logic [1:0]  blk_type;
  logic [63:0] value;
  logic        size_present;
  logic [2:0]  counter_id;
  logic        error_code;
  logic        last_of_run;

  modport source (output valid, output event_res, output frame_kind, output block_last,
                  output blk_type, output value, output size_present,
                  output counter_id, output error_code, output last_of_run, input ready);
  modport sink (input valid, input event_res, input frame_kind, input block_last,
                input blk_type, input value, input size_present,
                input counter_id, input error_code, input last_of_run, output ready);
endinterface

// ===== rtl/zstd_frame_scanner.sv =====
// zstd_frame_scanner: top level, frame parser plus result queue
//
//   channel   dir   payload                                          beat when
//   bytes     in    kind, data_byte                                  valid && ready
//   results   out   event_res .. last_of_run (one result)            valid && ready
//
// one byte per cycle; a byte's results are written to a 4-entry result queue
// in the cycle it is taken, so it may yield up to two results with no stall
// bytes stall while the queue holds more than two results or a counter report runs
// an end marker at a frame boundary gives six counter beats, one per cycle while
// the queue has room; bytes are held off until the sixth is queued, which takes
// longer while the result side stalls
// rst is synchronous and empties the queue
module zstd_frame_scanner #(
  parameter int COUNT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  zfs_in_if.sink    bytes,
  zfs_out_if.source results
);

  zfs_pkg::push_t              push;
  logic                        busy;
  logic                        accept;
  logic                        pop;
  logic                        space;
  zfs_pkg::res_t               q [zfs_pkg::QDEPTH];
  logic [zfs_pkg::QPTR_W-1:0]  wp, rp;
  logic [zfs_pkg::QCNT_W-1:0]  count;
  zfs_pkg::res_t               head;

  assign bytes.ready = !busy && (count <= zfs_pkg::QCNT_W'(zfs_pkg::QDEPTH - 2));
  assign accept      = bytes.valid && bytes.ready;
  assign space       = (count != zfs_pkg::QCNT_W'(zfs_pkg::QDEPTH));
  assign pop         = results.valid && results.ready;

  zfs_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (bytes.kind),
    .data_byte (bytes.data_byte),
    .space     (space),
    .busy      (busy),
    .push      (push)
  );

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q[wp] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      q[wp + zfs_pkg::QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + zfs_pkg::QPTR_W'(push.cnt);
      rp    <= rp + zfs_pkg::QPTR_W'(pop);
      count <= count + zfs_pkg::QCNT_W'(push.cnt) - zfs_pkg::QCNT_W'(pop);
    end
  end

  assign head = q[rp];

  assign results.valid        = (count != '0);
  assign results.event_res    = head.event_res;
  assign results.frame_kind   = head.frame_kind;
  assign results.block_last   = head.block_last;
  assign results.blk_type     = head.blk_type;
  assign results.value        = head.value;
  assign results.size_present = head.size_present;
  assign results.counter_id   = head.counter_id;
  assign results.error_code   = head.error_code;
  assign results.last_of_run  = head.last_of_run;

endmodule

// ===== rtl/zfs_parser.sv =====
// zfs_parser: frame phase tracking, frame counters and counter report sequencing
module zfs_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           kind,
  input  logic [7:0]     data_byte,
  input  logic           space,
  output logic           busy,
  output zfs_pkg::push_t push
);

  typedef enum logic [10:0] {
    PH_MAGIC = 11'b000_0000_0001,
    PH_SKLEN = 11'b000_0000_0010,
    PH_SKPAY = 11'b000_0000_0100,
    PH_DESC  = 11'b000_0000_1000,
    PH_WIN   = 11'b000_0001_0000,
    PH_DICT  = 11'b000_0010_0000,
    PH_FCS   = 11'b000_0100_0000,
    PH_BHDR  = 11'b000_1000_0000,
    PH_BPAY  = 11'b001_0000_0000,
    PH_CKSUM = 11'b010_0000_0000,
    PH_HALT  = 11'b100_0000_0000
  } phase_t;

  phase_t                   phase, phase_next;
  logic [3:0]               idx, idx_next;
  logic [63:0]              asm_f, asm_next;
  logic [31:0]              skip, skip_next;
  logic [7:0]               flags, flags_next;
  logic                     last_blk, last_blk_next;
  logic                     seen_fm, seen_fm_next;
  zfs_pkg::kind_t           cur_kind, cur_kind_next;
  logic                     rep_active, rep_active_next;
  logic [2:0]               rep_idx, rep_idx_next;
  logic [COUNT_WIDTH-1:0]   cnt [zfs_pkg::NUM_CNT];
  logic [zfs_pkg::NUM_CNT-1:0] bump;
  logic                     cnt_clr;

  function automatic logic [2:0] dict_size(input logic [7:0] f);
    case (f[1:0])
      2'd0:    dict_size = 3'd0;
      2'd3:    dict_size = 3'd4;
      default: dict_size = {1'b0, f[1:0]};
    endcase
  endfunction

  function automatic logic [3:0] fcs_size(input logic [7:0] f);
    case (f[7:6])
      2'd0:    fcs_size = f[5] ? 4'd1 : 4'd0;
      2'd1:    fcs_size = 4'd2;
      2'd2:    fcs_size = 4'd4;
      default: fcs_size = 4'd8;
    endcase
  endfunction

  function automatic zfs_pkg::res_t mk_res(input zfs_pkg::event_t ev,
                                           input zfs_pkg::kind_t fk,
                                           input logic bl, input logic [1:0] bt,
                                           input logic [63:0] v, input logic sp,
                                           input logic [2:0] cid,
                                           input zfs_pkg::err_t ec);
    zfs_pkg::res_t r;
    r.event_res    = ev;
    r.frame_kind   = fk;
    r.block_last   = bl;
    r.blk_type     = bt;
    r.value        = v;
    r.size_present = sp;
    r.counter_id   = cid;
    r.error_code   = ec;
    r.last_of_run  = 1'b0;
    mk_res = r;
  endfunction

  function automatic zfs_pkg::push_t add_res(input zfs_pkg::push_t p, input zfs_pkg::res_t r);
    zfs_pkg::push_t q;
    q = p;
    if (p.cnt == 2'd0) begin
      q.r0 = r;
    end else begin
      q.r1 = r;
    end
    q.cnt = p.cnt + 2'd1;
    add_res = q;
  endfunction

  always_comb begin
    logic [63:0] asm_b;
    logic [3:0]  idx_inc;
    logic [31:0] skip_dec;
    logic [31:0] m;
    logic [23:0] h;
    logic [31:0] bskip;
    logic [63:0] fcs_v;
    logic        do_hn;
    logic [1:0]  hn_stage;
    logic        do_bd;
    logic        do_fe;

    asm_b    = asm_f | (64'(data_byte) << {idx[2:0], 3'b000});
    idx_inc  = idx + 4'd1;
    skip_dec = (skip != 32'd0) ? skip - 32'd1 : 32'd0;
    m        = asm_b[31:0];
    h        = asm_b[23:0];
    bskip    = (h[2:1] == zfs_pkg::BT_RLE) ? 32'd1 : {11'b0, h[23:3]};
    fcs_v    = (fcs_size(flags) == 4'd2) ? {47'b0, 17'(asm_b[15:0]) + 17'd256} : asm_b;
    do_hn    = 1'b0;
    hn_stage = 2'd0;
    do_bd    = 1'b0;
    do_fe    = 1'b0;

    phase_next      = phase;
    idx_next        = idx;
    asm_next        = asm_f;
    skip_next       = skip;
    flags_next      = flags;
    last_blk_next   = last_blk;
    seen_fm_next    = seen_fm;
    cur_kind_next   = cur_kind;
    rep_active_next = rep_active;
    rep_idx_next    = rep_idx;
    bump            = '0;
    cnt_clr         = 1'b0;
    push            = '0;

    if (accept && !kind && phase != PH_HALT) begin
      case (phase)
        PH_MAGIC: begin
          asm_next = asm_b;
          idx_next = idx_inc;
          if (idx == 4'd3) begin
            idx_next   = 4'd0;
            asm_next   = 64'd0;
            phase_next = PH_SKLEN;
            if (m == zfs_pkg::MAGIC_DATA) begin
              cur_kind_next         = zfs_pkg::FK_DATA;
              bump[zfs_pkg::CID_DATA] = 1'b1;
              phase_next            = PH_DESC;
            end else if (m == zfs_pkg::MAGIC_CONTAINER) begin
              if (!seen_fm) begin
                cur_kind_next            = zfs_pkg::FK_FILE_MAGIC;
                seen_fm_next             = 1'b1;
                bump[zfs_pkg::CID_MAGIC] = 1'b1;
              end else begin
                cur_kind_next              = zfs_pkg::FK_GENOMIC;
                bump[zfs_pkg::CID_GENOMIC] = 1'b1;
              end
            end else if (m == zfs_pkg::MAGIC_PARALLEL) begin
              cur_kind_next               = zfs_pkg::FK_PARALLEL;
              bump[zfs_pkg::CID_PARALLEL] = 1'b1;
            end else if (m == zfs_pkg::MAGIC_SEEKABLE) begin
              cur_kind_next               = zfs_pkg::FK_SEEKABLE;
              bump[zfs_pkg::CID_SEEKABLE] = 1'b1;
            end else if (m[31:4] == zfs_pkg::MAGIC_PARALLEL[31:4]) begin
              cur_kind_next = zfs_pkg::FK_SKIPPABLE;
            end else begin
              push = add_res(push, mk_res(zfs_pkg::EV_ERROR, zfs_pkg::FK_FILE_MAGIC, 1'b0,
                                          2'd0, 64'(m), 1'b0, 3'd0, zfs_pkg::ERR_BAD_MAGIC));
              phase_next = PH_HALT;
            end
          end
        end
        PH_SKLEN: begin
          asm_next = asm_b;
          idx_next = idx_inc;
          if (idx == 4'd3) begin
            skip_next = m;
            push = add_res(push, mk_res(zfs_pkg::EV_HDR_DONE, cur_kind, 1'b0, 2'd0,
                                        64'(m), 1'b0, 3'd0, zfs_pkg::ERR_BAD_MAGIC));
            idx_next = 4'd0;
            asm_next = 64'd0;
            if (m == 32'd0) begin
              do_fe = 1'b1;
            end else begin
              phase_next = PH_SKPAY;
            end
          end
        end
        PH_SKPAY: begin
          skip_next = skip_dec;
          do_fe     = (skip_dec == 32'd0);
        end
        PH_DESC: begin
          flags_next = data_byte;
          do_hn      = 1'b1;
          hn_stage   = 2'd0;
        end
        PH_WIN: begin
          do_hn    = 1'b1;
          hn_stage = 2'd1;
        end
        PH_DICT: begin
          idx_next = idx_inc;
          if (idx_inc >= {1'b0, dict_size(flags)}) begin
            do_hn    = 1'b1;
            hn_stage = 2'd2;
          end
        end
        PH_FCS: begin
          asm_next = asm_b;
          idx_next = idx_inc;
          if (idx_inc >= fcs_size(flags)) begin
            push = add_res(push, mk_res(zfs_pkg::EV_HDR_DONE, zfs_pkg::FK_DATA, 1'b0, 2'd0,
                                        fcs_v, 1'b1, 3'd0, zfs_pkg::ERR_BAD_MAGIC));
            phase_next = PH_BHDR;
            idx_next   = 4'd0;
            asm_next   = 64'd0;
          end
        end
        PH_BHDR: begin
          asm_next = asm_b;
          idx_next = idx_inc;
          if (idx == 4'd2) begin
            last_blk_next             = h[0];
            bump[zfs_pkg::CID_BLOCKS] = 1'b1;
            push = add_res(push, mk_res(zfs_pkg::EV_BLOCK, zfs_pkg::FK_DATA, h[0], h[2:1],
                                        64'(h[23:3]), 1'b0, 3'd0, zfs_pkg::ERR_BAD_MAGIC));
            idx_next  = 4'd0;
            asm_next  = 64'd0;
            skip_next = bskip;
            if (bskip == 32'd0) begin
              do_bd = 1'b1;
            end else begin
              phase_next = PH_BPAY;
            end
          end
        end
        PH_BPAY: begin
          skip_next = skip_dec;
          do_bd     = (skip_dec == 32'd0);
        end
        PH_CKSUM: begin
          skip_next = skip_dec;
          do_fe     = (skip_dec == 32'd0);
        end
        default: begin
        end
      endcase

      if (do_hn) begin
        if (hn_stage == 2'd0 && !flags_next[5]) begin
          phase_next = PH_WIN;
        end else if (hn_stage != 2'd2 && dict_size(flags_next) != 3'd0) begin
          phase_next = PH_DICT;
          idx_next   = 4'd0;
        end else if (fcs_size(flags_next) != 4'd0) begin
          phase_next = PH_FCS;
          idx_next   = 4'd0;
          asm_next   = 64'd0;
        end else begin
          push = add_res(push, mk_res(zfs_pkg::EV_HDR_DONE, zfs_pkg::FK_DATA, 1'b0, 2'd0,
                                      64'd0, 1'b0, 3'd0, zfs_pkg::ERR_BAD_MAGIC));
          phase_next = PH_BHDR;
          idx_next   = 4'd0;
          asm_next   = 64'd0;
        end
      end

      if (do_bd) begin
        if (!last_blk_next) begin
          phase_next = PH_BHDR;
          idx_next   = 4'd0;
          asm_next   = 64'd0;
        end else if (flags[2]) begin
          phase_next = PH_CKSUM;
          skip_next  = 32'd4;
        end else begin
          do_fe = 1'b1;
        end
      end

      if (do_fe) begin
        push = add_res(push, mk_res(zfs_pkg::EV_FRM_END, cur_kind_next, 1'b0, 2'd0, 64'd0,
                                    1'b0, 3'd0, zfs_pkg::ERR_BAD_MAGIC));
        phase_next = PH_MAGIC;
        idx_next   = 4'd0;
        asm_next   = 64'd0;
      end
    end

    if (accept && kind) begin
      if (phase == PH_MAGIC) begin
        rep_active_next = 1'b1;
        rep_idx_next    = 3'd0;
      end else begin
        if (phase != PH_HALT) begin
          push = add_res(push, mk_res(zfs_pkg::EV_ERROR, zfs_pkg::FK_FILE_MAGIC, 1'b0, 2'd0,
                                      64'd0, 1'b0, 3'd0, zfs_pkg::ERR_TRUNCATED));
        end
        cnt_clr = 1'b1;
      end
      phase_next    = PH_MAGIC;
      idx_next      = 4'd0;
      asm_next      = 64'd0;
      skip_next     = 32'd0;
      flags_next    = 8'd0;
      last_blk_next = 1'b0;
      seen_fm_next  = 1'b0;
      cur_kind_next = zfs_pkg::FK_FILE_MAGIC;
    end

    // counter report, one beat per cycle while the queue has room
    if (rep_active && space) begin
      push = add_res(push, mk_res(zfs_pkg::EV_REPORT, zfs_pkg::FK_FILE_MAGIC, 1'b0, 2'd0,
                                  64'(cnt[rep_idx]), 1'b0, rep_idx, zfs_pkg::ERR_BAD_MAGIC));
      rep_idx_next = rep_idx + 3'd1;
      if (rep_idx == zfs_pkg::CID_BLOCKS) begin
        rep_active_next = 1'b0;
        cnt_clr         = 1'b1;
      end
    end

    if (push.cnt == 2'd1) begin
      push.r0.last_of_run = (push.r0.event_res != zfs_pkg::EV_REPORT) ||
                            (push.r0.counter_id == zfs_pkg::CID_BLOCKS);
    end else if (push.cnt == 2'd2) begin
      push.r1.last_of_run = 1'b1;
    end
  end

  assign busy = rep_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      idx        <= 4'd0;
      asm_f      <= 64'd0;
      skip       <= 32'd0;
      flags      <= 8'd0;
      last_blk   <= 1'b0;
      seen_fm    <= 1'b0;
      cur_kind   <= zfs_pkg::FK_FILE_MAGIC;
      rep_active <= 1'b0;
      rep_idx    <= 3'd0;
    end else begin
      phase      <= phase_next;
      idx        <= idx_next;
      asm_f      <= asm_next;
      skip       <= skip_next;
      flags      <= flags_next;
      last_blk   <= last_blk_next;
      seen_fm    <= seen_fm_next;
      cur_kind   <= cur_kind_next;
      rep_active <= rep_active_next;
      rep_idx    <= rep_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < zfs_pkg::NUM_CNT; i++) begin
      if (rst || cnt_clr) begin
        cnt[i] <= '0;
      end else if (bump[i]) begin
        cnt[i] <= cnt[i] + COUNT_WIDTH'(1);
      end
    end
  end

endmodule

// ===== rtl/zfs_checker.sv =====
// zfs_checker: port-level assertions for the zstd frame scanner, with its bind
module zfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [2:0]  frame_kind,
  input logic [63:0] value,
  input logic        size_present,
  input logic [2:0]  counter_id,
  input logic        error_code,
  input logic        last_of_run
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(event_res))
    else $error("result beat changed while stalled");

  // queue empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // counter report runs end on the blocks counter
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == zfs_pkg::EV_REPORT |->
      last_of_run == (counter_id == zfs_pkg::CID_BLOCKS))
    else $error("counter report last beat mismatch");

  // truncation error stands alone with no value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == zfs_pkg::EV_ERROR && error_code == zfs_pkg::ERR_TRUNCATED |->
      value == 64'd0 && last_of_run)
    else $error("bad truncation error beat");

  // data header without content size reports zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == zfs_pkg::EV_HDR_DONE && frame_kind == zfs_pkg::FK_DATA &&
      !size_present |-> value == 64'd0)
    else $error("data header value without size field");

endmodule

bind zstd_frame_scanner zfs_checker u_zfs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .event_res    (results.event_res),
  .frame_kind   (results.frame_kind),
  .value        (results.value),
  .size_present (results.size_present),
  .counter_id   (results.counter_id),
  .error_code   (results.error_code),
  .last_of_run  (results.last_of_run)
);

// ===== tb/tb_zstd_frame_scanner.sv =====
`timescale 1ns / 1ps
// tb_zstd_frame_scanner: frame predictor, scoreboard and byte stream stimulus for the scanner

class frame_tracker;
  typedef enum logic [3:0] {
    S_MAGIC, S_SKIP_LEN, S_SKIP_BODY, S_DESC, S_WINDOW, S_DICT, S_SIZE,
    S_BLK_HDR, S_BLK_BODY, S_CHECKSUM, S_HALTED
  } scan_phase_t;

  zfs_pkg::res_t  pending_events[$];
  int             fail_count;
  scan_phase_t    phase;
  logic [3:0]     nidx;
  logic [63:0]    accum;
  logic [31:0]    remaining;
  logic [7:0]     desc_flags;
  logic           last_blk;
  logic           file_magic_seen;
  logic           halted;
  logic [31:0]    counts[zfs_pkg::NUM_CNT];
  zfs_pkg::kind_t kind_now;

  function new();
    fail_count = 0;
    restart();
  endfunction

  function void to_magic();
    phase = S_MAGIC;
    nidx  = '0;
    accum = '0;
  endfunction

  function void restart();
    to_magic();
    remaining       = '0;
    desc_flags      = '0;
    last_blk        = 1'b0;
    file_magic_seen = 1'b0;
    halted          = 1'b0;
    kind_now        = zfs_pkg::FK_FILE_MAGIC;
    foreach (counts[i]) counts[i] = '0;
  endfunction

  function void push(zfs_pkg::event_t ev, zfs_pkg::kind_t fk, logic bl, logic [1:0] bt,
                     logic [63:0] val, logic sp, logic [2:0] cid, zfs_pkg::err_t ec);
    zfs_pkg::res_t r;
    r.event_res    = ev;
    r.frame_kind   = fk;
    r.block_last   = bl;
    r.blk_type     = bt;
    r.value        = val;
    r.size_present = sp;
    r.counter_id   = cid;
    r.error_code   = ec;
    r.last_of_run  = 1'b0;
    pending_events.push_back(r);
  endfunction

  function void frame_done();
    push(zfs_pkg::EV_FRM_END, kind_now, 1'b0, 2'd0, 64'd0, 1'b0, 3'd0,
         zfs_pkg::ERR_BAD_MAGIC);
    to_magic();
  endfunction

  function int dict_len();
    return (desc_flags[1:0] == 2'd3) ? 4 : int'(desc_flags[1:0]);
  endfunction

  function int size_len();
    if (desc_flags[7:6] == 2'd0) return desc_flags[5] ? 1 : 0;
    return 1 << desc_flags[7:6];
  endfunction

  function void to_block_hdr();
    phase = S_BLK_HDR;
    nidx  = '0;
    accum = '0;
  endfunction

  // stage 0 after descriptor, 1 after window byte, 2 after dictionary id
  function void header_step(int stage);
    if (stage < 1 && !desc_flags[5]) begin
      phase = S_WINDOW;
      return;
    end
    if (stage < 2 && dict_len() != 0) begin
      phase = S_DICT;
      nidx  = '0;
      return;
    end
    if (size_len() != 0) begin
      phase = S_SIZE;
      nidx  = '0;
      accum = '0;
      return;
    end
    push(zfs_pkg::EV_HDR_DONE, zfs_pkg::FK_DATA, 1'b0, 2'd0, 64'd0, 1'b0, 3'd0,
         zfs_pkg::ERR_BAD_MAGIC);
    to_block_hdr();
  endfunction

  function void block_step();
    if (!last_blk) begin
      to_block_hdr();
    end else if (desc_flags[2]) begin
      phase     = S_CHECKSUM;
      remaining = 32'd4;
    end else begin
      frame_done();
    end
  endfunction

  function void bump(logic [2:0] id);
    counts[id] = counts[id] + 32'd1;
  endfunction

  function void magic_step(logic [31:0] m);
    nidx  = '0;
    accum = '0;
    if (m == zfs_pkg::MAGIC_DATA) begin
      kind_now = zfs_pkg::FK_DATA;
      bump(zfs_pkg::CID_DATA);
      phase = S_DESC;
      return;
    end
    if (m == zfs_pkg::MAGIC_CONTAINER) begin
      if (!file_magic_seen) begin
        kind_now        = zfs_pkg::FK_FILE_MAGIC;
        file_magic_seen = 1'b1;
        bump(zfs_pkg::CID_MAGIC);
      end else begin
        kind_now = zfs_pkg::FK_GENOMIC;
        bump(zfs_pkg::CID_GENOMIC);
      end
    end else if (m == zfs_pkg::MAGIC_PARALLEL) begin
      kind_now = zfs_pkg::FK_PARALLEL;
      bump(zfs_pkg::CID_PARALLEL);
    end else if (m == zfs_pkg::MAGIC_SEEKABLE) begin
      kind_now = zfs_pkg::FK_SEEKABLE;
      bump(zfs_pkg::CID_SEEKABLE);
    end else if (m[31:4] == zfs_pkg::MAGIC_PARALLEL[31:4]) begin
      kind_now = zfs_pkg::FK_SKIPPABLE;
    end else begin
      push(zfs_pkg::EV_ERROR, zfs_pkg::FK_FILE_MAGIC, 1'b0, 2'd0, 64'(m), 1'b0, 3'd0,
           zfs_pkg::ERR_BAD_MAGIC);
      halted = 1'b1;
      phase  = S_HALTED;
      return;
    end
    phase = S_SKIP_LEN;
  endfunction

  function void byte_step(logic [7:0] b);
    logic [23:0] hdr;
    logic [63:0] v;
    case (phase)
      S_MAGIC, S_SKIP_LEN: begin
        accum |= 64'(b) << (8 * nidx[1:0]);
        nidx++;
        if (nidx == 4'd4) begin
          if (phase == S_MAGIC) begin
            magic_step(accum[31:0]);
          end else begin
            remaining = accum[31:0];
            push(zfs_pkg::EV_HDR_DONE, kind_now, 1'b0, 2'd0, 64'(remaining), 1'b0, 3'd0,
                 zfs_pkg::ERR_BAD_MAGIC);
            nidx  = '0;
            accum = '0;
            if (remaining == 0) frame_done();
            else phase = S_SKIP_BODY;
          end
        end
      end
      S_SKIP_BODY, S_BLK_BODY, S_CHECKSUM: begin
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          if (phase == S_BLK_BODY) block_step();
          else frame_done();
        end
      end
      S_DESC: begin
        desc_flags = b;
        header_step(0);
      end
      S_WINDOW: header_step(1);
      S_DICT: begin
        nidx++;
        if (nidx >= dict_len()) header_step(2);
      end
      S_SIZE: begin
        accum |= 64'(b) << (8 * nidx[2:0]);
        nidx++;
        if (nidx >= size_len()) begin
          v = accum;
          if (size_len() == 2) v += 64'd256;
          push(zfs_pkg::EV_HDR_DONE, zfs_pkg::FK_DATA, 1'b0, 2'd0, v, 1'b1, 3'd0,
               zfs_pkg::ERR_BAD_MAGIC);
          to_block_hdr();
        end
      end
      S_BLK_HDR: begin
        accum |= 64'(b) << (8 * nidx[1:0]);
        nidx++;
        if (nidx == 4'd3) begin
          hdr      = accum[23:0];
          last_blk = hdr[0];
          bump(zfs_pkg::CID_BLOCKS);
          push(zfs_pkg::EV_BLOCK, zfs_pkg::FK_DATA, hdr[0], hdr[2:1], 64'(hdr[23:3]), 1'b0,
               3'd0, zfs_pkg::ERR_BAD_MAGIC);
          nidx      = '0;
          accum     = '0;
          remaining = (hdr[2:1] == zfs_pkg::BT_RLE) ? 32'd1 : 32'(hdr[23:3]);
          if (remaining == 0) block_step();
          else phase = S_BLK_BODY;
        end
      end
      default: ;
    endcase
  endfunction

  function void note_beat(logic is_end, logic [7:0] b);
    int            start;
    zfs_pkg::res_t tail;
    start = pending_events.size();
    if (!is_end) begin
      if (!halted && phase != S_HALTED) byte_step(b);
    end else begin
      if (!halted) begin
        if (phase != S_MAGIC) begin
          push(zfs_pkg::EV_ERROR, zfs_pkg::FK_FILE_MAGIC, 1'b0, 2'd0, 64'd0, 1'b0, 3'd0,
               zfs_pkg::ERR_TRUNCATED);
        end else begin
          for (int i = 0; i < zfs_pkg::NUM_CNT; i++)
            push(zfs_pkg::EV_REPORT, zfs_pkg::FK_FILE_MAGIC, 1'b0, 2'd0, 64'(counts[i]),
                 1'b0, 3'(i), zfs_pkg::ERR_BAD_MAGIC);
        end
      end
      restart();
    end
    if (pending_events.size() > start) begin
      tail = pending_events.pop_back();
      tail.last_of_run = 1'b1;
      pending_events.push_back(tail);
    end
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task check_result(zfs_pkg::res_t got);
    zfs_pkg::res_t want;
    if (pending_events.size() == 0) begin
      report($sformatf("result %h with nothing pending", got));
      return;
    end
    want = pending_events.pop_front();
    if (got.event_res !== want.event_res)
      report($sformatf("event_res %0d want %0d", got.event_res, want.event_res));
    if (got.frame_kind !== want.frame_kind)
      report($sformatf("frame_kind %0d want %0d", got.frame_kind, want.frame_kind));
    if (got.block_last !== want.block_last)
      report($sformatf("block_last %0d want %0d", got.block_last, want.block_last));
    if (got.blk_type !== want.blk_type)
      report($sformatf("blk_type %0d want %0d", got.blk_type, want.blk_type));
    if (got.value !== want.value)
      report($sformatf("value %h want %h", got.value, want.value));
    if (got.size_present !== want.size_present)
      report($sformatf("size_present %0d want %0d", got.size_present, want.size_present));
    if (got.counter_id !== want.counter_id)
      report($sformatf("counter_id %0d want %0d", got.counter_id, want.counter_id));
    if (got.error_code !== want.error_code)
      report($sformatf("error_code %0d want %0d", got.error_code, want.error_code));
    if (got.last_of_run !== want.last_of_run)
      report($sformatf("last_of_run %0d want %0d", got.last_of_run, want.last_of_run));
  endtask
endclass

module tb_zstd_frame_scanner;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 190;
  localparam int QUIET_TAIL = 40;
  localparam int LONG_HOLD = 60;

  typedef struct packed {
    logic       is_end;
    logic [7:0] b;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  zfs_in_if  byte_ch ();
  zfs_out_if result_ch ();

  frame_tracker tracker = new();
  beat_t        stim_q[$];
  beat_t        frame_buf[$];
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;
  int           cycles = 0;
  int           directed_len;

  zstd_frame_scanner dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .results(result_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("zstd_frame_scanner verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : sample
    zfs_pkg::res_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.event_res    = zfs_pkg::event_t'(result_ch.event_res);
      got.frame_kind   = zfs_pkg::kind_t'(result_ch.frame_kind);
      got.block_last   = result_ch.block_last;
      got.blk_type     = result_ch.blk_type;
      got.value        = result_ch.value;
      got.size_present = result_ch.size_present;
      got.counter_id   = result_ch.counter_id;
      got.error_code   = zfs_pkg::err_t'(result_ch.error_code);
      got.last_of_run  = result_ch.last_of_run;
      tracker.check_result(got);
    end
  end

  initial begin : receiver
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end else if (hold == 0 && !calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 3);
      end
      if (hold > 0) begin
        result_ch.ready = 1'b0;
        hold--;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  function void put(logic is_end, logic [7:0] b);
    frame_buf.push_back({is_end, b});
  endfunction

  function void put_word(logic [31:0] w, int n);
    for (int i = 0; i < n; i++) put(1'b0, w[8*i +: 8]);
  endfunction

  function void put_random(int n);
    repeat (n) put(1'b0, 8'($urandom));
  endfunction

  function void put_end();
    stim_q.push_back({1'b1, 8'($urandom)});
  endfunction

  function void commit(int n);
    for (int i = 0; i < n && i < frame_buf.size(); i++) stim_q.push_back(frame_buf[i]);
    frame_buf.delete();
  endfunction

  function zfs_pkg::kind_t pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return zfs_pkg::FK_DATA;
    if (r < 7) return zfs_pkg::FK_FILE_MAGIC;
    if (r == 7) return zfs_pkg::FK_PARALLEL;
    if (r == 8) return zfs_pkg::FK_SEEKABLE;
    return zfs_pkg::FK_SKIPPABLE;
  endfunction

  // payloads are capped, so a huge frame whose declared payload exceeds the cap never completes
  function void build_frame(zfs_pkg::kind_t k, bit huge);
    logic [31:0] magic;
    logic [31:0] len;
    logic [7:0]  desc;
    logic [3:0]  nib;
    logic [1:0]  btype;
    logic [20:0] bsize;
    int          nblk;
    int          pay;
    if (k == zfs_pkg::FK_DATA) begin
      desc = 8'($urandom);
      put_word(zfs_pkg::MAGIC_DATA, 4);
      put(1'b0, desc);
      if (!desc[5]) put_random(1);
      put_random(desc[1:0] == 2'd3 ? 4 : int'(desc[1:0]));
      if (desc[7:6] == 2'd0) put_random(desc[5] ? 1 : 0);
      else put_random(1 << desc[7:6]);
      nblk = $urandom_range(1, 3);
      for (int i = 0; i < nblk; i++) begin
        btype = 2'($urandom_range(0, 3));
        bsize = huge ? 21'($urandom_range(0, 21'h1FFFFF)) : 21'($urandom_range(0, 5));
        put_word({8'd0, bsize, btype, 1'(i == nblk - 1)}, 3);
        pay = (btype == zfs_pkg::BT_RLE) ? 1 : int'(bsize);
        put_random(pay > 6 ? 6 : pay);
      end
      if (desc[2]) put_random(4);
    end else begin
      case (k)
        zfs_pkg::FK_PARALLEL: magic = zfs_pkg::MAGIC_PARALLEL;
        zfs_pkg::FK_SEEKABLE: magic = zfs_pkg::MAGIC_SEEKABLE;
        zfs_pkg::FK_SKIPPABLE: begin
          nib = 4'($urandom_range(1, 15));
          if (nib == zfs_pkg::MAGIC_CONTAINER[3:0] || nib == zfs_pkg::MAGIC_SEEKABLE[3:0])
            nib = 4'h3;
          magic = {zfs_pkg::MAGIC_PARALLEL[31:4], nib};
        end
        default: magic = zfs_pkg::MAGIC_CONTAINER;
      endcase
      len = huge ? $urandom : 32'($urandom_range(0, 6));
      put_word(magic, 4);
      put_word(len, 4);
      put_random(len > 6 ? 6 : int'(len));
    end
  endfunction

  function void gen_stream();
    int way;
    bit huge;
    way = $urandom_range(0, 19);
    repeat ($urandom_range(1, 3)) begin
      build_frame(pick_kind(), 1'b0);
      commit(frame_buf.size());
    end
    if (way >= 14 && way < 16) begin
      // partial magic then end
      put_word($urandom_range(0, 1) ? zfs_pkg::MAGIC_DATA : $urandom, 4);
      commit($urandom_range(1, 3));
    end else if (way >= 16 && way < 18) begin
      huge = 1'($urandom_range(0, 1));
      build_frame(pick_kind(), huge);
      commit(huge ? frame_buf.size() : $urandom_range(1, frame_buf.size() - 1));
    end else if (way >= 18) begin
      put_word($urandom, 4);
      put_random($urandom_range(0, 4));
      commit(frame_buf.size());
    end
    put_end();
  endfunction

  task automatic drive_beat(beat_t s);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      byte_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    byte_ch.valid     = 1'b1;
    byte_ch.kind      = s.is_end;
    byte_ch.data_byte = s.b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tracker.note_beat(s.is_end, s.b);
  endtask

  initial begin : stimulus
    byte_ch.valid     = 1'b0;
    byte_ch.kind      = 1'b0;
    byte_ch.data_byte = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // empty file magic frame, then a clean end with all counters
    put_word(zfs_pkg::MAGIC_CONTAINER, 4);
    put_word(32'd0, 4);
    commit(frame_buf.size());
    put_end();
    // stream ends on a partial magic
    put_word(zfs_pkg::MAGIC_DATA, 4);
    commit(2);
    put_end();
    // illegal magic, ignored byte, silent end
    put_word(32'hFFFF_FFFF, 4);
    put(1'b0, 8'h00);
    commit(frame_buf.size());
    put_end();
    // data header with every descriptor bit set, cut short
    put_word(zfs_pkg::MAGIC_DATA, 4);
    put(1'b0, 8'hFF);
    commit(frame_buf.size());
    put_end();
    directed_len = stim_q.size();

    while (stim_q.size() < directed_len + RANDOM_BEATS) gen_stream();

    for (int i = 0; i < stim_q.size(); i++) begin
      calm = (i >= stim_q.size() - QUIET_TAIL);
      drive_beat(stim_q[i]);
      if (i == directed_len || i == directed_len + 100) hold_req = 1'b1;
    end
    @(negedge clk) byte_ch.valid = 1'b0;

    while (tracker.pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.fail_count == 0) $display("zstd_frame_scanner verification clean");
    else $display("zstd_frame_scanner verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/zfs_pkg.sv
rtl/zfs_in_if.sv
rtl/zfs_out_if.sv
rtl/zfs_parser.sv
rtl/zstd_frame_scanner.sv
rtl/zfs_checker.sv
tb/tb_zstd_frame_scanner.sv
